// ===== rtl/jsu_pkg.sv =====
// Shared types, character codes and UTF-8 helpers for the JSON string unescaper.
// No dependencies; the modules and testbench refer to it by scoped names.
package jsu_pkg;

  // Result kinds and error codes as seen on the output channel
  typedef enum logic [1:0] {
    KIND_DATA  = 2'd0,
    KIND_CLOSE = 2'd1,
    KIND_ERROR = 2'd2
  } kind_e;

  typedef enum logic [1:0] {
    ERR_NONE       = 2'd0,
    ERR_UNTERM     = 2'd1,
    ERR_INCOMPLETE = 2'd2,
    ERR_BAD_HEX    = 2'd3
  } err_e;

  // Parser states, one-hot
  typedef enum logic [6:0] {
    MODE_NORMAL  = 7'b0000001,
    MODE_ESC     = 7'b0000010,
    MODE_HEX1    = 7'b0000100,
    MODE_WANT_BS = 7'b0001000,
    MODE_WANT_U  = 7'b0010000,
    MODE_HEX2    = 7'b0100000,
    MODE_DONE    = 7'b1000000
  } mode_e;

  // Character codes
  localparam logic [7:0] CH_QUOTE  = 8'h22;
  localparam logic [7:0] CH_BSLASH = 8'h5C;
  localparam logic [7:0] CH_U      = 8'h75;
  localparam logic [7:0] CH_N      = 8'h6E;
  localparam logic [7:0] CH_T      = 8'h74;
  localparam logic [7:0] CH_R      = 8'h72;
  localparam logic [7:0] CH_B      = 8'h62;
  localparam logic [7:0] CH_F      = 8'h66;
  localparam logic [7:0] CH_LF     = 8'h0A;
  localparam logic [7:0] CH_TAB    = 8'h09;
  localparam logic [7:0] CH_CR     = 8'h0D;
  localparam logic [7:0] CH_BS     = 8'h08;
  localparam logic [7:0] CH_FF     = 8'h0C;

  // Surrogate tags (top six bits of a 16-bit unit) and code point limits
  localparam logic [5:0]  HIGH_SURR_TAG = 6'b110110;
  localparam logic [5:0]  LOW_SURR_TAG  = 6'b110111;
  localparam logic [20:0] SUPP_BASE     = 21'h10000;
  localparam logic [20:0] UTF8_LIM1     = 21'h00080;
  localparam logic [20:0] UTF8_LIM2     = 21'h00800;
  localparam logic [20:0] UTF8_LIM3     = 21'h10000;

  // Work handed from the parser to the output sequencer: an optional code
  // point, then an optional literal byte, then an optional close/error word.
  typedef struct packed {
    logic        has_cp;
    logic [20:0] cp;
    logic        has_raw;
    logic [7:0]  raw_byte;
    logic        has_tail;
    kind_e       tail_kind;
    err_e        tail_err;
  } desc_t;

  // Number of UTF-8 bytes for a code point
  function automatic logic [2:0] utf8_len(input logic [20:0] cp);
    logic [2:0] n;
    if (cp < UTF8_LIM1) begin
      n = 3'd1;
    end else if (cp < UTF8_LIM2) begin
      n = 3'd2;
    end else if (cp < UTF8_LIM3) begin
      n = 3'd3;
    end else begin
      n = 3'd4;
    end
    return n;
  endfunction

  // Byte k of the n-byte UTF-8 form of cp
  function automatic logic [7:0] utf8_byte(input logic [20:0] cp, input logic [2:0] n,
                                           input logic [2:0] k);
    logic [7:0] b;
    b = 8'h00;
    case (n)
      3'd1: b = {1'b0, cp[6:0]};
      3'd2: b = (k == 3'd0) ? {3'b110, cp[10:6]} : {2'b10, cp[5:0]};
      3'd3: begin
        case (k)
          3'd0:    b = {4'b1110, cp[15:12]};
          3'd1:    b = {2'b10, cp[11:6]};
          default: b = {2'b10, cp[5:0]};
        endcase
      end
      default: begin
        case (k)
          3'd0:    b = {5'b11110, cp[20:18]};
          3'd1:    b = {2'b10, cp[17:12]};
          3'd2:    b = {2'b10, cp[11:6]};
          default: b = {2'b10, cp[5:0]};
        endcase
      end
    endcase
    return b;
  endfunction

endpackage

// ===== rtl/jsu_in_if.sv =====
// Input channel of the JSON string unescaper: valid/ready plus one input word.
// No dependencies.
interface jsu_in_if;
  logic       valid;
  logic       ready;
  logic       cmd;
  logic [7:0] in_byte;
  logic       end_of_text;

  modport source (output valid, cmd, in_byte, end_of_text, input ready);
  modport sink   (input valid, cmd, in_byte, end_of_text, output ready);
endinterface

// ===== rtl/jsu_out_if.sv =====
// Output channel of the JSON string unescaper: valid/ready plus one result word.
// No dependencies.
interface jsu_out_if;
  logic       valid;
  logic       ready;
  logic [7:0] out_byte;
  logic [1:0] kind;
  logic [1:0] err_code;
  logic       last_of_run;

  modport source (output valid, out_byte, kind, err_code, last_of_run, input ready);
  modport sink   (input valid, out_byte, kind, err_code, last_of_run, output ready);
endinterface

// ===== rtl/json_string_unescape_utf8.sv =====
// JSON string body unescaper with UTF-8 output.
// The first result word of an input word goes into the descriptor queue, then the
// output register. Throughput: one input word per cycle while each yields at most one
// result and the output accepts; the sequencer sends one result word per cycle while
// the output accepts, and a word with up to 5 results holds it, absorbed by the queue.
// Reset (rst_ni low, async): parser to body state, queue and output emptied.
module json_string_unescape_utf8 #(
  parameter int QueueDepth = 2
) (
  input  logic       clk_i,
  input  logic       rst_ni,
  jsu_in_if.sink     in_i,
  jsu_out_if.source  out_o
);

  logic            push;
  logic            full;
  logic            pop;
  logic            empty;
  jsu_pkg::desc_t  desc;
  jsu_pkg::desc_t  head;

  // parser front end
  jsu_front u_front (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .in_i   (in_i),
    .full_i (full),
    .push_o (push),
    .desc_o (desc)
  );

  // decoupling queue
  jsu_queue #(
    .Depth (QueueDepth)
  ) u_queue (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .push_i  (push),
    .desc_i  (desc),
    .full_o  (full),
    .pop_i   (pop),
    .empty_o (empty),
    .head_o  (head)
  );

  // output sequencer
  jsu_back u_back (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .empty_i (empty),
    .head_i  (head),
    .pop_o   (pop),
    .out_o   (out_o)
  );

endmodule

// ===== rtl/jsu_front.sv =====
// Parser front end: accepts input words, tracks escape/hex/surrogate state and
// emits one work descriptor per word that yields results. Uses jsu_pkg, jsu_in_if.
module jsu_front (
  input  logic            clk_i,
  input  logic            rst_ni,
  jsu_in_if.sink          in_i,
  input  logic            full_i,
  output logic            push_o,
  output jsu_pkg::desc_t  desc_o
);

  jsu_pkg::mode_e mode_q, mode_d;
  logic [2:0]     cnt_q, cnt_d;
  logic [15:0]    hex_q, hex_d;
  logic [9:0]     held_q, held_d;
  logic           bad_q, bad_d;

  logic           accept;
  logic [7:0]     b;
  logic           eot;
  logic [3:0]     dig;
  logic           is_hex;
  logic [2:0]     cnt_next;
  logic [15:0]    hex_next;
  logic           bad_next;
  logic [20:0]    held_cp;

  // body-byte handling, shared by normal and after-surrogate states
  logic           body_raw;
  logic           body_close;
  logic           body_unterm;
  jsu_pkg::mode_e body_mode;

  // escape-character handling, shared by backslash and after-surrogate states
  logic [7:0]     esc_val;

  jsu_pkg::desc_t desc;

  assign in_i.ready = !full_i;
  assign accept     = in_i.valid && in_i.ready;
  assign b          = in_i.in_byte;
  assign eot        = in_i.end_of_text;
  assign held_cp    = {5'd0, jsu_pkg::HIGH_SURR_TAG, held_q};

  // hex digit decode and accumulation
  always_comb begin
    is_hex = 1'b1;
    dig    = 4'd0;
    if (b >= 8'h30 && b <= 8'h39) begin
      dig = 4'(b - 8'h30);
    end else if (b >= 8'h61 && b <= 8'h66) begin
      dig = 4'(b - 8'h57);
    end else if (b >= 8'h41 && b <= 8'h46) begin
      dig = 4'(b - 8'h37);
    end else begin
      is_hex = 1'b0;
    end
  end

  assign cnt_next = cnt_q + 3'd1;
  assign hex_next = {hex_q[11:0], dig};
  assign bad_next = bad_q | !is_hex;

  // body byte: quote closes, backslash (not at end of text) opens an escape, anything else is data
  always_comb begin
    body_raw    = 1'b0;
    body_close  = 1'b0;
    body_unterm = 1'b0;
    body_mode   = jsu_pkg::MODE_NORMAL;
    if (b == jsu_pkg::CH_QUOTE) begin
      body_close = 1'b1;
      body_mode  = jsu_pkg::MODE_DONE;
    end else if (b == jsu_pkg::CH_BSLASH && !eot) begin
      body_mode = jsu_pkg::MODE_ESC;
    end else begin
      body_raw = 1'b1;
      if (eot) begin
        body_unterm = 1'b1;
        body_mode   = jsu_pkg::MODE_DONE;
      end
    end
  end

  // simple escape mapping; unknown characters pass through
  always_comb begin
    case (b)
      jsu_pkg::CH_N: esc_val = jsu_pkg::CH_LF;
      jsu_pkg::CH_T: esc_val = jsu_pkg::CH_TAB;
      jsu_pkg::CH_R: esc_val = jsu_pkg::CH_CR;
      jsu_pkg::CH_B: esc_val = jsu_pkg::CH_BS;
      jsu_pkg::CH_F: esc_val = jsu_pkg::CH_FF;
      default:       esc_val = b;
    endcase
  end

  // next state and descriptor
  always_comb begin
    mode_d = mode_q;
    cnt_d  = cnt_q;
    hex_d  = hex_q;
    held_d = held_q;
    bad_d  = bad_q;
    desc   = '0;
    desc.tail_kind = jsu_pkg::KIND_ERROR;
    desc.tail_err  = jsu_pkg::ERR_UNTERM;

    case (mode_q)
      jsu_pkg::MODE_NORMAL: begin
        desc.has_raw  = body_raw;
        desc.raw_byte = b;
        if (body_close) begin
          desc.has_tail  = 1'b1;
          desc.tail_kind = jsu_pkg::KIND_CLOSE;
          desc.tail_err  = jsu_pkg::ERR_NONE;
        end
        desc.has_tail = desc.has_tail | body_unterm;
        mode_d = body_mode;
      end

      jsu_pkg::MODE_ESC: begin
        if (b == jsu_pkg::CH_U) begin
          cnt_d  = 3'd0;
          hex_d  = 16'd0;
          bad_d  = 1'b0;
          mode_d = jsu_pkg::MODE_HEX1;
          if (eot) begin
            desc.has_tail = 1'b1;
            desc.tail_err = jsu_pkg::ERR_INCOMPLETE;
            mode_d        = jsu_pkg::MODE_DONE;
          end
        end else begin
          desc.has_raw  = 1'b1;
          desc.raw_byte = esc_val;
          desc.has_tail = eot;
          mode_d        = eot ? jsu_pkg::MODE_DONE : jsu_pkg::MODE_NORMAL;
        end
      end

      jsu_pkg::MODE_HEX1, jsu_pkg::MODE_HEX2: begin
        cnt_d = cnt_next;
        hex_d = hex_next;
        bad_d = bad_next;
        if (cnt_next != 3'd4) begin
          if (eot) begin
            desc.has_tail = 1'b1;
            desc.tail_err = jsu_pkg::ERR_INCOMPLETE;
            mode_d        = jsu_pkg::MODE_DONE;
          end
        end else if (bad_next) begin
          desc.has_tail = 1'b1;
          desc.tail_err = jsu_pkg::ERR_BAD_HEX;
          mode_d        = jsu_pkg::MODE_DONE;
        end else if (mode_q == jsu_pkg::MODE_HEX1) begin
          if (hex_next[15:10] == jsu_pkg::HIGH_SURR_TAG) begin
            // hold the high surrogate; at end of text flush it alone at once
            held_d = hex_next[9:0];
            mode_d = jsu_pkg::MODE_WANT_BS;
            if (eot) begin
              desc.has_cp   = 1'b1;
              desc.cp       = {5'd0, hex_next};
              desc.has_tail = 1'b1;
              mode_d        = jsu_pkg::MODE_DONE;
            end
          end else begin
            desc.has_cp   = 1'b1;
            desc.cp       = {5'd0, hex_next};
            desc.has_tail = eot;
            mode_d        = eot ? jsu_pkg::MODE_DONE : jsu_pkg::MODE_NORMAL;
          end
        end else begin
          // second unit: join a low surrogate, otherwise emit the high one alone
          desc.has_cp = 1'b1;
          if (hex_next[15:10] == jsu_pkg::LOW_SURR_TAG) begin
            desc.cp = jsu_pkg::SUPP_BASE + {1'b0, held_q, hex_next[9:0]};
          end else begin
            desc.cp = held_cp;
          end
          desc.has_tail = eot;
          mode_d        = eot ? jsu_pkg::MODE_DONE : jsu_pkg::MODE_NORMAL;
        end
      end

      jsu_pkg::MODE_WANT_BS: begin
        if (b == jsu_pkg::CH_BSLASH && !eot) begin
          mode_d = jsu_pkg::MODE_WANT_U;
        end else begin
          desc.has_cp   = 1'b1;
          desc.cp       = held_cp;
          desc.has_raw  = body_raw;
          desc.raw_byte = b;
          if (body_close) begin
            desc.has_tail  = 1'b1;
            desc.tail_kind = jsu_pkg::KIND_CLOSE;
            desc.tail_err  = jsu_pkg::ERR_NONE;
          end
          desc.has_tail = desc.has_tail | body_unterm;
          mode_d = body_mode;
        end
      end

      jsu_pkg::MODE_WANT_U: begin
        if (b == jsu_pkg::CH_U) begin
          cnt_d  = 3'd0;
          hex_d  = 16'd0;
          bad_d  = 1'b0;
          mode_d = jsu_pkg::MODE_HEX2;
          if (eot) begin
            desc.has_tail = 1'b1;
            desc.tail_err = jsu_pkg::ERR_INCOMPLETE;
            mode_d        = jsu_pkg::MODE_DONE;
          end
        end else begin
          desc.has_cp   = 1'b1;
          desc.cp       = held_cp;
          desc.has_raw  = 1'b1;
          desc.raw_byte = esc_val;
          desc.has_tail = eot;
          mode_d        = eot ? jsu_pkg::MODE_DONE : jsu_pkg::MODE_NORMAL;
        end
      end

      default: begin
        mode_d = jsu_pkg::MODE_DONE;
      end
    endcase

    // restart wipes the parser and yields nothing
    if (in_i.cmd) begin
      mode_d = jsu_pkg::MODE_NORMAL;
      cnt_d  = 3'd0;
      hex_d  = 16'd0;
      held_d = 10'd0;
      bad_d  = 1'b0;
      desc   = '0;
    end
  end

  assign push_o = accept && (desc.has_cp || desc.has_raw || desc.has_tail);
  assign desc_o = desc;

  // parser state registers
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      mode_q <= jsu_pkg::MODE_NORMAL;
      cnt_q  <= 3'd0;
      hex_q  <= 16'd0;
      held_q <= 10'd0;
      bad_q  <= 1'b0;
    end else if (accept) begin
      mode_q <= mode_d;
      cnt_q  <= cnt_d;
      hex_q  <= hex_d;
      held_q <= held_d;
      bad_q  <= bad_d;
    end
  end

endmodule

// ===== rtl/jsu_queue.sv =====
// Short descriptor queue between the parser and the output sequencer.
// Uses jsu_pkg for the descriptor type.
module jsu_queue #(
  parameter int Depth = 2
) (
  input  logic            clk_i,
  input  logic            rst_ni,
  input  logic            push_i,
  input  jsu_pkg::desc_t  desc_i,
  output logic            full_o,
  input  logic            pop_i,
  output logic            empty_o,
  output jsu_pkg::desc_t  head_o
);

  localparam int PtrW = $clog2(Depth);
  localparam int CntW = $clog2(Depth + 1);
  localparam logic [PtrW-1:0] LastPtr = PtrW'(Depth - 1);
  localparam logic [CntW-1:0] FullCnt = CntW'(Depth);

  jsu_pkg::desc_t     mem_q [Depth];
  logic [PtrW-1:0]    wr_q, wr_d;
  logic [PtrW-1:0]    rd_q, rd_d;
  logic [CntW-1:0]    cnt_q, cnt_d;
  logic               do_push;
  logic               do_pop;

  assign full_o  = (cnt_q == FullCnt);
  assign empty_o = (cnt_q == '0);
  assign head_o  = mem_q[rd_q];
  assign do_push = push_i && !full_o;
  assign do_pop  = pop_i && !empty_o;

  // pointer and count update
  always_comb begin
    wr_d  = wr_q;
    rd_d  = rd_q;
    cnt_d = cnt_q;
    if (do_push) begin
      wr_d = (wr_q == LastPtr) ? '0 : wr_q + PtrW'(1);
    end
    if (do_pop) begin
      rd_d = (rd_q == LastPtr) ? '0 : rd_q + PtrW'(1);
    end
    if (do_push && !do_pop) begin
      cnt_d = cnt_q + CntW'(1);
    end else if (do_pop && !do_push) begin
      cnt_d = cnt_q - CntW'(1);
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_q  <= '0;
      rd_q  <= '0;
      cnt_q <= '0;
    end else begin
      wr_q  <= wr_d;
      rd_q  <= rd_d;
      cnt_q <= cnt_d;
    end
  end

  // entry storage
  always_ff @(posedge clk_i) begin
    if (do_push) begin
      mem_q[wr_q] <= desc_i;
    end
  end

endmodule

// ===== rtl/jsu_back.sv =====
// Output sequencer: expands one descriptor into its UTF-8, literal and
// close/error words, one word per cycle while the output accepts, into the output register.
// Uses jsu_pkg, jsu_out_if.
module jsu_back (
  input  logic            clk_i,
  input  logic            rst_ni,
  input  logic            empty_i,
  input  jsu_pkg::desc_t  head_i,
  output logic            pop_o,
  jsu_out_if.source       out_o
);

  logic [2:0]      idx_q, idx_d;
  logic            valid_q, valid_d;
  logic [7:0]      byte_q, byte_d;
  jsu_pkg::kind_e  kind_q, kind_d;
  jsu_pkg::err_e   err_q, err_d;
  logic            last_q, last_d;

  logic [2:0]      n_cp;
  logic [2:0]      n_data;
  logic [2:0]      n_total;
  logic            load;

  assign n_cp    = head_i.has_cp ? jsu_pkg::utf8_len(head_i.cp) : 3'd0;
  assign n_data  = n_cp + {2'b00, head_i.has_raw};
  assign n_total = n_data + {2'b00, head_i.has_tail};
  assign load    = !empty_i && (!valid_q || out_o.ready);
  assign pop_o   = load && last_d;

  // pick the word at the current position of the run
  always_comb begin
    kind_d = jsu_pkg::KIND_DATA;
    err_d  = jsu_pkg::ERR_NONE;
    if (idx_q < n_cp) begin
      byte_d = jsu_pkg::utf8_byte(head_i.cp, n_cp, idx_q);
    end else if (idx_q < n_data) begin
      byte_d = head_i.raw_byte;
    end else begin
      byte_d = 8'h00;
      kind_d = head_i.tail_kind;
      err_d  = head_i.tail_err;
    end
    last_d = (idx_q == n_total - 3'd1);
  end

  always_comb begin
    idx_d   = idx_q;
    valid_d = valid_q;
    if (load) begin
      idx_d   = last_d ? 3'd0 : idx_q + 3'd1;
      valid_d = 1'b1;
    end else if (out_o.ready) begin
      valid_d = 1'b0;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      idx_q   <= 3'd0;
      valid_q <= 1'b0;
    end else begin
      idx_q   <= idx_d;
      valid_q <= valid_d;
    end
  end

  // output word register
  always_ff @(posedge clk_i) begin
    if (load) begin
      byte_q <= byte_d;
      kind_q <= kind_d;
      err_q  <= err_d;
      last_q <= last_d;
    end
  end

  assign out_o.valid       = valid_q;
  assign out_o.out_byte    = byte_q;
  assign out_o.kind        = kind_q;
  assign out_o.err_code    = err_q;
  assign out_o.last_of_run = last_q;

endmodule

// ===== dv/json_string_unescape_utf8_tb.sv =====
`timescale 1ns / 100ps
// Self-checking testbench for json_string_unescape_utf8: directed strings, then random strings.
// Needs jsu_pkg, jsu_in_if, jsu_out_if and the unescaper RTL; a local parser model predicts
// every result word, and a checker compares them in order on the output channel.
module json_string_unescape_utf8_tb;

  localparam int CYCLE_LIMIT = 100000;
  localparam int SETTLE_CYCLES = 10;
  localparam int MAX_PRINTED = 40;
  localparam logic [7:0] CH_SLASH = 8'h2F;

  typedef struct {
    logic [7:0]      out_byte;
    jsu_pkg::kind_e  kind;
    jsu_pkg::err_e   err_code;
    logic            last_of_run;
  } result_word_t;

  typedef enum int {END_QUOTE, END_EOT, END_OPEN} string_end_e;

  logic clk_i;
  logic rst_ni;

  jsu_in_if  in_ch ();
  jsu_out_if out_ch ();

  json_string_unescape_utf8 u_dut (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .in_i   (in_ch),
    .out_o  (out_ch)
  );

  // Parser model state
  jsu_pkg::mode_e pmode;
  logic [2:0]     pdigits;
  logic [15:0]    phex;
  logic [15:0]    phigh;
  logic           pbad;

  result_word_t step_words[$];
  result_word_t expected_words[$];
  logic [7:0]   text_bytes[$];

  int src_idle_pct;
  int snk_idle_pct;
  int mismatch_count = 0;
  int live_items = 0;
  int cycle_count = 0;

  initial begin
    clk_i = 1'b0;
    forever #4 clk_i = ~clk_i;
  end

  // ---------------------------------------------------------------------------
  // Parser model
  // ---------------------------------------------------------------------------
  function automatic void reset_predictor();
    pmode   = jsu_pkg::MODE_NORMAL;
    pdigits = 3'd0;
    phex    = 16'h0000;
    phigh   = 16'h0000;
    pbad    = 1'b0;
  endfunction

  function automatic void emit_word(input logic [7:0] b, input jsu_pkg::kind_e k,
                                    input jsu_pkg::err_e e);
    result_word_t w;
    w.out_byte    = b;
    w.kind        = k;
    w.err_code    = e;
    w.last_of_run = 1'b0;
    step_words.insert(step_words.size(), w);
  endfunction

  function automatic void emit_data(input logic [7:0] b);
    emit_word(b, jsu_pkg::KIND_DATA, jsu_pkg::ERR_NONE);
  endfunction

  // UTF-8 encoding of one code point, one to four data words
  function automatic void emit_code_point(input logic [20:0] cp);
    if (cp < 21'h80) begin
      emit_data(cp[7:0]);
    end else if (cp < 21'h800) begin
      emit_data(8'hC0 | cp[10:6]);
      emit_data(8'h80 | cp[5:0]);
    end else if (cp < 21'h10000) begin
      emit_data(8'hE0 | cp[15:12]);
      emit_data(8'h80 | cp[11:6]);
      emit_data(8'h80 | cp[5:0]);
    end else begin
      emit_data(8'hF0 | cp[20:18]);
      emit_data(8'h80 | cp[17:12]);
      emit_data(8'h80 | cp[11:6]);
      emit_data(8'h80 | cp[5:0]);
    end
  endfunction

  function automatic void raise_error(input jsu_pkg::err_e e);
    emit_word(8'h00, jsu_pkg::KIND_ERROR, e);
    pmode = jsu_pkg::MODE_DONE;
  endfunction

  function automatic void close_if_end(input logic eot);
    if (eot) raise_error(jsu_pkg::ERR_UNTERM);
  endfunction

  function automatic void begin_hex(input jsu_pkg::mode_e next_mode, input logic eot);
    pdigits = 3'd0;
    phex    = 16'h0000;
    pbad    = 1'b0;
    pmode   = next_mode;
    if (eot) raise_error(jsu_pkg::ERR_INCOMPLETE);
  endfunction

  function automatic void body_char(input logic [7:0] b, input logic eot);
    if (b == jsu_pkg::CH_QUOTE) begin
      emit_word(8'h00, jsu_pkg::KIND_CLOSE, jsu_pkg::ERR_NONE);
      pmode = jsu_pkg::MODE_DONE;
    end else if (b == jsu_pkg::CH_BSLASH && !eot) begin
      pmode = jsu_pkg::MODE_ESC;
    end else begin
      emit_data(b);
      pmode = jsu_pkg::MODE_NORMAL;
      close_if_end(eot);
    end
  endfunction

  function automatic void escape_char(input logic [7:0] b, input logic eot);
    logic [7:0] v;
    v = b;
    if (b == jsu_pkg::CH_U) begin
      begin_hex(jsu_pkg::MODE_HEX1, eot);
    end else begin
      case (b)
        jsu_pkg::CH_N: v = jsu_pkg::CH_LF;
        jsu_pkg::CH_T: v = jsu_pkg::CH_TAB;
        jsu_pkg::CH_R: v = jsu_pkg::CH_CR;
        jsu_pkg::CH_B: v = jsu_pkg::CH_BS;
        jsu_pkg::CH_F: v = jsu_pkg::CH_FF;
        default:       v = b;
      endcase
      emit_data(v);
      pmode = jsu_pkg::MODE_NORMAL;
      close_if_end(eot);
    end
  endfunction

  // True once four clean digits are in; a non-hex byte still takes a digit slot
  function automatic bit take_hex_digit(input logic [7:0] b, input logic eot);
    logic [3:0] d;
    d = 4'd0;
    if (b >= 8'h30 && b <= 8'h39) begin
      d = b[3:0];
    end else if ((b >= 8'h61 && b <= 8'h66) || (b >= 8'h41 && b <= 8'h46)) begin
      d = b[3:0] + 4'd9;  // low nibble of a-f / A-F is 1..6
    end else begin
      pbad = 1'b1;
    end
    phex    = {phex[11:0], d};
    pdigits = pdigits + 3'd1;
    if (pdigits < 3'd4) begin
      if (eot) raise_error(jsu_pkg::ERR_INCOMPLETE);
      return 1'b0;
    end
    if (pbad) begin
      raise_error(jsu_pkg::ERR_BAD_HEX);
      return 1'b0;
    end
    return 1'b1;
  endfunction

  // Expected result words for one accepted input word
  function automatic void predict_unescape(input logic cmd, input logic [7:0] b,
                                           input logic eot);
    logic [15:0] hi_off;
    logic [15:0] lo_off;
    step_words.delete();
    if (cmd) begin
      reset_predictor();
    end else begin
      case (pmode)
        jsu_pkg::MODE_NORMAL: body_char(b, eot);
        jsu_pkg::MODE_ESC:    escape_char(b, eot);
        jsu_pkg::MODE_HEX1: begin
          if (take_hex_digit(b, eot)) begin
            if (phex >= 16'hD800 && phex <= 16'hDBFF) begin
              phigh = phex;
              pmode = jsu_pkg::MODE_WANT_BS;
              if (eot) begin
                emit_code_point({5'd0, phex});
                raise_error(jsu_pkg::ERR_UNTERM);
              end
            end else begin
              emit_code_point({5'd0, phex});
              pmode = jsu_pkg::MODE_NORMAL;
              close_if_end(eot);
            end
          end
        end
        jsu_pkg::MODE_WANT_BS: begin
          if (b == jsu_pkg::CH_BSLASH && !eot) begin
            pmode = jsu_pkg::MODE_WANT_U;
          end else begin
            emit_code_point({5'd0, phigh});
            body_char(b, eot);
          end
        end
        jsu_pkg::MODE_WANT_U: begin
          if (b == jsu_pkg::CH_U) begin
            begin_hex(jsu_pkg::MODE_HEX2, eot);
          end else begin
            emit_code_point({5'd0, phigh});
            escape_char(b, eot);
          end
        end
        jsu_pkg::MODE_HEX2: begin
          if (take_hex_digit(b, eot)) begin
            // join the pair, or drop a second unit that is not a low surrogate
            if (phex >= 16'hDC00 && phex <= 16'hDFFF) begin
              hi_off = phigh - 16'hD800;
              lo_off = phex - 16'hDC00;
              emit_code_point(21'h10000 + {1'b0, hi_off[9:0], lo_off[9:0]});
            end else begin
              emit_code_point({5'd0, phigh});
            end
            pmode = jsu_pkg::MODE_NORMAL;
            close_if_end(eot);
          end
        end
        default: pmode = jsu_pkg::MODE_DONE;
      endcase
    end
    if (step_words.size() > 0) step_words[step_words.size() - 1].last_of_run = 1'b1;
    foreach (step_words[i]) expected_words.insert(expected_words.size(), step_words[i]);
  endfunction

  // ---------------------------------------------------------------------------
  // Driving and checking
  // ---------------------------------------------------------------------------
  task automatic report_mismatch(input string msg);
    if (mismatch_count < MAX_PRINTED) $display("%0t: %s", $time, msg);
    mismatch_count++;
  endtask

  // One input word; called and returns at a rising edge
  task automatic send_word(input logic cmd, input logic [7:0] b, input logic eot);
    logic taken;
    while ($urandom_range(0, 99) < src_idle_pct) begin
      in_ch.valid <= 1'b0;
      @(posedge clk_i);
    end
    in_ch.valid       <= 1'b1;
    in_ch.cmd         <= cmd;
    in_ch.in_byte     <= b;
    in_ch.end_of_text <= eot;
    taken = 1'b0;
    while (!taken) begin
      @(negedge clk_i);
      taken = in_ch.ready;
      @(posedge clk_i);
    end
    if (cmd || pmode != jsu_pkg::MODE_DONE) live_items++;
    predict_unescape(cmd, b, eot);
  endtask

  function automatic logic [7:0] random_byte();
    logic [7:0] r;
    r = 8'($urandom);
    return r;
  endfunction

  task automatic send_restart();
    send_word(1'b1, random_byte(), 1'($urandom_range(0, 1)));
  endtask

  task automatic send_text(input string s, input bit eot_last);
    for (int i = 0; i < s.len(); i++) send_word(1'b0, s[i], eot_last && (i == s.len() - 1));
  endtask

  // Hold the input off until every predicted word has come out
  task automatic wait_all_results();
    in_ch.valid <= 1'b0;
    do @(posedge clk_i); while (expected_words.size() != 0);
  endtask

  // Downstream backpressure
  always @(posedge clk_i) out_ch.ready <= ($urandom_range(0, 99) >= snk_idle_pct);

  // Sample between edges: a word seen here is taken at the next rising edge
  always @(negedge clk_i) begin : check_results
    result_word_t want;
    if (rst_ni && out_ch.valid && out_ch.ready) begin
      if (expected_words.size() == 0) begin
        report_mismatch($sformatf("result word %0h kind %0d with nothing expected",
                                  out_ch.out_byte, out_ch.kind));
      end else begin
        want = expected_words.pop_front();
        if (out_ch.out_byte !== want.out_byte)
          report_mismatch($sformatf("out_byte got %0h want %0h", out_ch.out_byte,
                                    want.out_byte));
        if (out_ch.kind !== want.kind)
          report_mismatch($sformatf("kind got %0d want %0d", out_ch.kind, want.kind));
        if (out_ch.err_code !== want.err_code)
          report_mismatch($sformatf("err_code got %0d want %0d", out_ch.err_code,
                                    want.err_code));
        if (out_ch.last_of_run !== want.last_of_run)
          report_mismatch($sformatf("last_of_run got %0b want %0b", out_ch.last_of_run,
                                    want.last_of_run));
      end
    end
  end

  // ---------------------------------------------------------------------------
  // Random string builder
  // ---------------------------------------------------------------------------
  function automatic logic [7:0] nibble_to_ascii(input logic [3:0] n, input bit upper);
    logic [7:0] c;
    if (n < 4'd10) c = 8'h30 + n;
    else c = (upper ? 8'h41 : 8'h61) + n - 8'd10;
    return c;
  endfunction

  function automatic void push_unicode(input logic [15:0] v);
    text_bytes.insert(text_bytes.size(), jsu_pkg::CH_BSLASH);
    text_bytes.insert(text_bytes.size(), jsu_pkg::CH_U);
    for (int i = 3; i >= 0; i--)
      text_bytes.insert(text_bytes.size(),
                        nibble_to_ascii(v[i*4 +: 4], 1'($urandom_range(0, 1))));
  endfunction

  // Code unit drawn from each UTF-8 length class and both surrogate halves
  function automatic logic [15:0] pick_code_unit();
    logic [15:0] v;
    case ($urandom_range(0, 4))
      0:       v = 16'($urandom_range(0, 16'h7F));
      1:       v = 16'($urandom_range(16'h80, 16'h7FF));
      2:       v = 16'($urandom_range(16'h800, 16'hFFFF));
      3:       v = 16'($urandom_range(16'hD800, 16'hDBFF));
      default: v = 16'($urandom_range(16'hDC00, 16'hDFFF));
    endcase
    return v;
  endfunction

  function automatic logic [15:0] pick_high_surrogate();
    logic [15:0] v;
    v = 16'($urandom_range(16'hD800, 16'hDBFF));
    return v;
  endfunction

  // Mostly well-formed bodies with random content, some broken pieces
  function automatic string_end_e build_random_string();
    logic [7:0] esc_letters[8];
    int k;
    int r;
    esc_letters = '{jsu_pkg::CH_N, jsu_pkg::CH_T, jsu_pkg::CH_R, jsu_pkg::CH_B,
                    jsu_pkg::CH_F, jsu_pkg::CH_QUOTE, jsu_pkg::CH_BSLASH, CH_SLASH};
    text_bytes.delete();
    repeat ($urandom_range(1, 6)) begin
      case ($urandom_range(0, 9))
        0, 1, 2: text_bytes.insert(text_bytes.size(), random_byte());
        3, 4: begin
          k = $urandom_range(0, 8);
          text_bytes.insert(text_bytes.size(), jsu_pkg::CH_BSLASH);
          text_bytes.insert(text_bytes.size(), (k == 8) ? random_byte() : esc_letters[k]);
        end
        5, 6: push_unicode(pick_code_unit());
        7, 8: begin
          push_unicode(pick_high_surrogate());
          if ($urandom_range(0, 3) != 0) push_unicode(pick_code_unit() | 16'hDC00);
          else push_unicode(pick_code_unit());
        end
        default: begin
          case ($urandom_range(0, 2))
            0: begin
              push_unicode(pick_high_surrogate());
              text_bytes.insert(text_bytes.size(), random_byte());
            end
            1: begin
              push_unicode(pick_high_surrogate());
              text_bytes.insert(text_bytes.size(), jsu_pkg::CH_BSLASH);
              text_bytes.insert(text_bytes.size(), random_byte());
            end
            default: begin
              // corrupt one digit position
              push_unicode(pick_code_unit());
              text_bytes[text_bytes.size() - 1 - $urandom_range(0, 3)] = random_byte();
            end
          endcase
        end
      endcase
    end
    r = $urandom_range(0, 9);
    if (r < 7) begin
      text_bytes.insert(text_bytes.size(), jsu_pkg::CH_QUOTE);
      repeat ($urandom_range(0, 2)) text_bytes.insert(text_bytes.size(), random_byte());
      return END_QUOTE;
    end
    return (r < 9) ? END_EOT : END_OPEN;
  endfunction

  // ---------------------------------------------------------------------------
  // Tests
  // ---------------------------------------------------------------------------
  task automatic test_plain_and_escapes();
    send_restart();
    send_word(1'b0, 8'h00, 1'b0);
    send_word(1'b0, 8'hFF, 1'b0);
    send_text("\\n\\/\\q\"", 1'b0);
  endtask

  // Pair to a four-byte code point, end of text on its last digit
  task automatic test_surrogate_pair();
    send_restart();
    send_text("\\uD83D\\ude00", 1'b1);
  endtask

  task automatic test_end_of_text();
    send_restart();
    send_text("\\", 1'b1);
    send_restart();
    send_text("\\u0A", 1'b1);
    send_restart();
    send_text("\\u20aC", 1'b1);
    send_restart();
    send_text("\\uD800", 1'b1);
  endtask

  // Quote and G fill digit slots; the error shows only at the fourth
  task automatic test_bad_hex();
    send_restart();
    send_text("\\u0\"G7a", 1'b0);
  endtask

  task automatic test_lone_surrogates();
    send_restart();
    send_text("\\uD800x\\uDBFF\\n\\uDBFF\\u0041\\uDC00\"", 1'b0);
  endtask

  task automatic test_ignored_after_close();
    send_restart();
    send_text("\"ab", 1'b0);
    send_restart();
    send_text("c", 1'b1);
  endtask

  task automatic test_random_strings(input int n_items);
    int first;
    int last_ix;
    logic eot;
    string_end_e how;
    first = live_items;
    while (live_items - first < n_items) begin
      how = build_random_string();
      send_restart();
      last_ix = text_bytes.size() - 1;
      foreach (text_bytes[i]) begin
        eot = ((i == last_ix) && how == END_EOT) || ($urandom_range(0, 49) == 0);
        send_word(1'b0, text_bytes[i], eot);
      end
    end
  endtask

  // ---------------------------------------------------------------------------
  // Sequence
  // ---------------------------------------------------------------------------
  initial begin
    in_ch.valid       <= 1'b0;
    in_ch.cmd         <= 1'b0;
    in_ch.in_byte     <= 8'h00;
    in_ch.end_of_text <= 1'b0;
    rst_ni            <= 1'b0;
    reset_predictor();
    src_idle_pct = 37;
    snk_idle_pct = 61;
    repeat (12) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    test_plain_and_escapes();
    test_surrogate_pair();
    test_end_of_text();
    test_bad_hex();
    test_lone_surrogates();
    test_ignored_after_close();
    test_random_strings(15);
    wait_all_results();

    src_idle_pct = 61;
    snk_idle_pct = 37;
    test_random_strings(15);
    wait_all_results();

    src_idle_pct = 0;
    snk_idle_pct = 0;
    test_random_strings(15);
    wait_all_results();

    repeat (SETTLE_CYCLES) @(posedge clk_i);
    if (mismatch_count == 0) begin
      $display("No mismatches found");
    end else begin
      $display("Mismatches found");
    end
    $finish;
  end

  // Watchdog
  initial begin : watchdog
    while (cycle_count < CYCLE_LIMIT) begin
      @(posedge clk_i);
      cycle_count++;
    end
    $display("Mismatches found");
    $finish;
  end

endmodule
